// ===== rtl/bfha_pkg.sv =====
// bfha_pkg: shared types and codes for the best-fit heap allocator core
// no dependencies
`timescale 1ns / 1ps

package bfha_pkg;

  localparam int CMD_W    = 2;
  localparam int REQ_W    = 12;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ZERO_SIZE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_AWALK,
    ST_ASPLIT,
    ST_APREV,
    ST_ABEST,
    ST_FCHK,
    ST_FWALK,
    ST_FBLK,
    ST_FCUR
  } state_t;

endpackage

// ===== rtl/bfha_ram.sv =====
// bfha_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/best_fit_heap_allocator_core.sv =====
// best_fit_heap_allocator_core: best-fit free-list allocator over a header ram
// depends on bfha_pkg and bfha_ram
// init, no-op, zero size and offsets below the header: strobe in the cycle after the transfer
// allocate: quotient, walk over the free headers (one header read per cycle), split, relink, mark, then the strobe
// free: quotient and header check when the block becomes the new head, else also walk, block link and predecessor link
// the single ram read port sets the pace of the walks; a walk visits at most one node per slot
// one command at a time; results cannot be stalled and show for one cycle on done
// reset: a clearing pass over all HEAP_BYTES/ALIGN_BYTES slots zeroes the headers, busy high
`timescale 1ns / 1ps

module best_fit_heap_allocator_core #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfha_pkg::CMD_W-1:0]    command,
  input  logic                          fresh,
  input  logic [bfha_pkg::REQ_W-1:0]    request_size,
  input  logic [bfha_pkg::OFF_W-1:0]    release_offset,
  output logic                          done,
  output logic [bfha_pkg::OFF_W-1:0]    payload_offset,
  output logic [bfha_pkg::STATUS_W-1:0] status
);

  localparam int SLOTS    = HEAP_BYTES / ALIGN_BYTES;
  localparam int SLW      = $clog2(SLOTS);
  localparam int HDR_SPAN = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int HS       = HDR_SPAN / ALIGN_BYTES;
  localparam int DW       = 13;
  localparam int RS       = DW + $clog2(ALIGN_BYTES);
  localparam int RM       = (2**RS + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int PW       = DW + RS;
  localparam int SW       = ($clog2(HEAP_BYTES) + 1 > DW) ? $clog2(HEAP_BYTES) + 1 : DW;
  localparam int XW       = SW + 2;
  localparam int EW       = SW + SLW + 2;

  bfha_pkg::state_t state, state_next;

  logic [DW-1:0]  div_q, div_q_next;
  logic           op_alloc, op_alloc_next;
  logic [DW-1:0]  need_slots, need_slots_next;
  logic [SW-1:0]  need, need_next;
  logic [SLW-1:0] cur, cur_next;
  logic [SLW-1:0] n, n_next;
  logic           fin, fin_next;
  logic           found, found_next;
  logic [SLW-1:0] best, best_next;
  logic [SW-1:0]  best_diff, best_diff_next;
  logic [SW-1:0]  best_size, best_size_next;
  logic [SLW-1:0] best_link, best_link_next;
  logic           best_lv, best_lv_next;
  logic [SLW-1:0] bprev, bprev_next;
  logic [SW-1:0]  bprev_size, bprev_size_next;
  logic           bprev_used, bprev_used_next;
  logic           bhas_prev, bhas_prev_next;
  logic [SLW-1:0] prev, prev_next;
  logic [SW-1:0]  prev_size, prev_size_next;
  logic           prev_used, prev_used_next;
  logic           have_prev, have_prev_next;
  logic           split, split_next;
  logic [SLW-1:0] split_slot, split_slot_next;
  logic [SLW-1:0] nxt, nxt_next;
  logic           nxtv, nxtv_next;
  logic [SW-1:0]  cur_size, cur_size_next;
  logic           cur_used, cur_used_next;
  logic [SLW-1:0] cur_link, cur_link_next;
  logic           cur_lv, cur_lv_next;
  logic [SLW-1:0] head, head_next;
  logic           head_v, head_v_next;
  logic           done_next;
  logic [bfha_pkg::OFF_W-1:0]    payload_offset_next;
  logic [bfha_pkg::STATUS_W-1:0] status_next;

  // header ram
  logic           ram_we;
  logic [SLW-1:0] ram_waddr;
  logic [EW-1:0]  ram_wdata;
  logic [SLW-1:0] ram_raddr;
  logic [EW-1:0]  ram_rdata;

  bfha_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // header fields from read data
  logic [SW-1:0]  rd_size;
  logic           rd_used;
  logic [SLW-1:0] rd_link;
  logic           rd_lv;
  assign rd_size = ram_rdata[EW-1 -: SW];
  assign rd_used = ram_rdata[SLW+1];
  assign rd_link = ram_rdata[SLW:1];
  assign rd_lv   = ram_rdata[0];

  // quotient by the alignment through a reciprocal multiply, exact over DW bits
  logic [PW-1:0] quo_x;
  logic [DW-1:0] quo;
  assign quo_x = PW'(div_q) * PW'(RM);
  assign quo   = quo_x[PW-1:RS];

  // arithmetic used in the allocate path
  logic [XW-1:0] need_x;
  logic [SW-1:0] fit_diff;
  logic          fits;
  logic [SW-1:0] rem;
  logic [XW-1:0] split_x;
  logic [XW-1:0] off_x;
  assign need_x   = XW'(quo) * XW'(ALIGN_BYTES);
  assign fit_diff = rd_size - need;
  assign fits     = (rd_size >= need) && (!found || fit_diff <= best_diff);
  assign rem      = best_size - need;
  assign split_x  = XW'(best) + XW'(HS) + XW'(need_slots);
  assign off_x    = XW'(best) * XW'(ALIGN_BYTES) + XW'(HDR_SPAN);

  assign busy = (state != bfha_pkg::ST_IDLE);

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bfha_pkg::ST_CLEAR;
      cur    <= '0;
      head   <= '0;
      head_v <= 1'b1;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      head   <= head_next;
      head_v <= head_v_next;
      done   <= done_next;
    end
    div_q          <= div_q_next;
    op_alloc       <= op_alloc_next;
    need_slots     <= need_slots_next;
    need           <= need_next;
    n              <= n_next;
    fin            <= fin_next;
    found          <= found_next;
    best           <= best_next;
    best_diff      <= best_diff_next;
    best_size      <= best_size_next;
    best_link      <= best_link_next;
    best_lv        <= best_lv_next;
    bprev          <= bprev_next;
    bprev_size     <= bprev_size_next;
    bprev_used     <= bprev_used_next;
    bhas_prev      <= bhas_prev_next;
    prev           <= prev_next;
    prev_size      <= prev_size_next;
    prev_used      <= prev_used_next;
    have_prev      <= have_prev_next;
    split          <= split_next;
    split_slot     <= split_slot_next;
    nxt            <= nxt_next;
    nxtv           <= nxtv_next;
    cur_size       <= cur_size_next;
    cur_used       <= cur_used_next;
    cur_link       <= cur_link_next;
    cur_lv         <= cur_lv_next;
    payload_offset <= payload_offset_next;
    status         <= status_next;
  end

  // next state, ram control and result
  always_comb begin
    state_next          = state;
    div_q_next          = div_q;
    op_alloc_next       = op_alloc;
    need_slots_next     = need_slots;
    need_next           = need;
    cur_next            = cur;
    n_next              = n;
    fin_next            = fin;
    found_next          = found;
    best_next           = best;
    best_diff_next      = best_diff;
    best_size_next      = best_size;
    best_link_next      = best_link;
    best_lv_next        = best_lv;
    bprev_next          = bprev;
    bprev_size_next     = bprev_size;
    bprev_used_next     = bprev_used;
    bhas_prev_next      = bhas_prev;
    prev_next           = prev;
    prev_size_next      = prev_size;
    prev_used_next      = prev_used;
    have_prev_next      = have_prev;
    split_next          = split;
    split_slot_next     = split_slot;
    nxt_next            = nxt;
    nxtv_next           = nxtv;
    cur_size_next       = cur_size;
    cur_used_next       = cur_used;
    cur_link_next       = cur_link;
    cur_lv_next         = cur_lv;
    head_next           = head;
    head_v_next         = head_v;
    done_next           = 1'b0;
    payload_offset_next = payload_offset;
    status_next         = status;
    ram_we              = 1'b0;
    ram_waddr           = cur;
    ram_wdata           = '0;
    ram_raddr           = cur;

    case (state)
      // zero every header after reset
      bfha_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cur;
        ram_wdata = '0;
        cur_next  = cur + SLW'(1);
        if (cur == SLW'(SLOTS - 1)) begin
          state_next = bfha_pkg::ST_IDLE;
        end
      end

      // take a command transfer
      bfha_pkg::ST_IDLE: begin
        if (start) begin
          payload_offset_next = '0;
          status_next         = bfha_pkg::STAT_OK;
          case (command)
            bfha_pkg::CMD_INIT: begin
              if (fresh) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {SW'(HEAP_BYTES - HDR_SPAN), 1'b0, SLW'(0), 1'b0};
              end
              head_next   = '0;
              head_v_next = 1'b1;
              done_next   = 1'b1;
            end
            bfha_pkg::CMD_ALLOC: begin
              op_alloc_next = 1'b1;
              div_q_next    = DW'(request_size) + DW'(ALIGN_BYTES - 1);
              if (request_size == '0) begin
                status_next = bfha_pkg::STAT_ZERO_SIZE;
                done_next   = 1'b1;
              end else begin
                state_next = bfha_pkg::ST_DIV;
              end
            end
            bfha_pkg::CMD_FREE: begin
              op_alloc_next = 1'b0;
              div_q_next    = DW'(release_offset) - DW'(HDR_SPAN);
              if (XW'(release_offset) < XW'(HDR_SPAN)) begin
                status_next = bfha_pkg::STAT_NOT_ALLOC;
                done_next   = 1'b1;
              end else begin
                state_next = bfha_pkg::ST_DIV;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // slot count from the quotient; then start the list access
      bfha_pkg::ST_DIV: begin
        if (op_alloc) begin
          need_slots_next = quo;
          need_next       = SW'(need_x);
          found_next      = 1'b0;
          have_prev_next  = 1'b0;
          n_next          = '0;
          cur_next        = head;
          ram_raddr       = head;
          if (!head_v) begin
            status_next = bfha_pkg::STAT_NO_FIT;
            done_next   = 1'b1;
            state_next  = bfha_pkg::ST_IDLE;
          end else begin
            state_next = bfha_pkg::ST_AWALK;
          end
        end else begin
          best_next = SLW'(quo);
          ram_raddr = SLW'(quo);
          if (need_x != XW'(div_q) || XW'(quo) >= XW'(SLOTS)) begin
            status_next = bfha_pkg::STAT_NOT_ALLOC;
            done_next   = 1'b1;
            state_next  = bfha_pkg::ST_IDLE;
          end else begin
            state_next = bfha_pkg::ST_FCHK;
          end
        end
      end

      // best-fit walk, one free header per cycle
      bfha_pkg::ST_AWALK: begin
        if (fits) begin
          found_next      = 1'b1;
          best_next       = cur;
          best_diff_next  = fit_diff;
          best_size_next  = rd_size;
          best_link_next  = rd_link;
          best_lv_next    = rd_lv;
          bprev_next      = prev;
          bprev_size_next = prev_size;
          bprev_used_next = prev_used;
          bhas_prev_next  = have_prev;
        end
        prev_next      = cur;
        prev_size_next = rd_size;
        prev_used_next = rd_used;
        have_prev_next = 1'b1;
        n_next         = n + SLW'(1);
        cur_next       = rd_link;
        ram_raddr      = rd_link;
        if (!rd_lv || n == SLW'(SLOTS - 1)) begin
          if (!(found || fits)) begin
            status_next = bfha_pkg::STAT_NO_FIT;
            done_next   = 1'b1;
            state_next  = bfha_pkg::ST_IDLE;
          end else begin
            state_next = bfha_pkg::ST_ASPLIT;
          end
        end
      end

      // split off the remainder when it is large enough
      bfha_pkg::ST_ASPLIT: begin
        split_slot_next = SLW'(split_x);
        nxt_next        = best_link;
        nxtv_next       = best_lv;
        split_next      = 1'b0;
        if (XW'(rem) > XW'(HEADER_BYTES + ALIGN_BYTES) && split_x < XW'(SLOTS)) begin
          split_next = 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = SLW'(split_x);
          ram_wdata  = {SW'(rem - SW'(HDR_SPAN)), 1'b0, best_link, best_lv};
          nxt_next   = SLW'(split_x);
          nxtv_next  = 1'b1;
        end
        state_next = bfha_pkg::ST_APREV;
      end

      // relink the predecessor or the list head
      bfha_pkg::ST_APREV: begin
        if (bhas_prev) begin
          ram_we    = 1'b1;
          ram_waddr = bprev;
          if (split && split_slot == bprev) begin
            ram_wdata = {SW'(rem - SW'(HDR_SPAN)), 1'b0, nxt, nxtv};
          end else begin
            ram_wdata = {bprev_size, bprev_used, nxt, nxtv};
          end
        end else begin
          head_next   = nxt;
          head_v_next = nxtv;
        end
        state_next = bfha_pkg::ST_ABEST;
      end

      // mark the chosen block allocated
      bfha_pkg::ST_ABEST: begin
        ram_we              = 1'b1;
        ram_waddr           = best;
        ram_wdata           = {need, 1'b1, SLW'(0), 1'b0};
        payload_offset_next = off_x[bfha_pkg::OFF_W-1:0];
        status_next         = bfha_pkg::STAT_OK;
        done_next           = 1'b1;
        state_next          = bfha_pkg::ST_IDLE;
      end

      // check the released header; insert it as the new head when the list is empty or it lies below the head
      bfha_pkg::ST_FCHK: begin
        best_size_next = rd_size;
        cur_next       = head;
        ram_raddr      = head;
        n_next         = '0;
        fin_next       = 1'b0;
        if (!rd_used) begin
          status_next = bfha_pkg::STAT_NOT_ALLOC;
          done_next   = 1'b1;
          state_next  = bfha_pkg::ST_IDLE;
        end else if (!head_v || best < head) begin
          ram_we      = 1'b1;
          ram_waddr   = best;
          ram_wdata   = {rd_size, 1'b0, head, head_v};
          head_next   = best;
          head_v_next = 1'b1;
          done_next   = 1'b1;
          state_next  = bfha_pkg::ST_IDLE;
        end else begin
          state_next = bfha_pkg::ST_FWALK;
        end
      end

      // walk to the last free header below the released one
      bfha_pkg::ST_FWALK: begin
        cur_size_next = rd_size;
        cur_used_next = rd_used;
        cur_link_next = rd_link;
        cur_lv_next   = rd_lv;
        ram_raddr     = rd_link;
        if (fin || !rd_lv || rd_link >= best) begin
          state_next = bfha_pkg::ST_FBLK;
        end else begin
          cur_next = rd_link;
          n_next   = n + SLW'(1);
          if (n == SLW'(SLOTS - 1)) begin
            fin_next = 1'b1;
          end
        end
      end

      // link the released block to the successor
      bfha_pkg::ST_FBLK: begin
        ram_we     = 1'b1;
        ram_waddr  = best;
        ram_wdata  = {best_size, 1'b0, cur_link, cur_lv};
        state_next = bfha_pkg::ST_FCUR;
      end

      // point the predecessor at the released block
      bfha_pkg::ST_FCUR: begin
        ram_we     = 1'b1;
        ram_waddr  = cur;
        ram_wdata  = {cur_size, cur_used && (cur != best), best, 1'b1};
        done_next  = 1'b1;
        state_next = bfha_pkg::ST_IDLE;
      end

      default: begin
        state_next = bfha_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bfha_checker.sv =====
// bfha_checker: port-level assertions for the allocator core, bound into every core instance
// depends on bfha_pkg and best_fit_heap_allocator_core
`timescale 1ns / 1ps

module bfha_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [bfha_pkg::CMD_W-1:0]    command,
  input logic                          done,
  input logic [bfha_pkg::OFF_W-1:0]    payload_offset,
  input logic [bfha_pkg::STATUS_W-1:0] status
);

  // a result only appears once the core is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // every command transfer is followed by work or a result
  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("command transfer dropped");

  // a non-zero offset only comes with a successful allocate
  a_offset_ok: assert property (@(posedge clk) disable iff (rst)
    (done && payload_offset != '0) |-> (status == bfha_pkg::STAT_OK))
    else $error("offset with failure status");

  // the clearing pass holds the core busy after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> (busy && !done))
    else $error("core not clearing after reset");

  // init and no-op finish in the next cycle
  a_init_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == bfha_pkg::CMD_INIT || command == bfha_pkg::CMD_NOP))
    |=> (done && status == bfha_pkg::STAT_OK))
    else $error("init or no-op result missing");

endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .command        (command),
  .done           (done),
  .payload_offset (payload_offset),
  .status         (status)
);

// ===== tb/best_fit_heap_allocator_core_tb.sv =====
// best_fit_heap_allocator_core_tb: self-checking bench for the best-fit heap allocator core
// drives init, allocate, free and no-op commands and checks every result strobe
// depends on bfha_pkg and best_fit_heap_allocator_core
`timescale 1ns / 1ps

module best_fit_heap_allocator_core_tb;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int HDR_SPAN     = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int SLOTS        = HEAP_BYTES / ALIGN_BYTES;
  localparam int BATCHES      = 47;
  localparam int BATCH_LEN    = 20;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    logic [bfha_pkg::CMD_W-1:0] cmd;
    logic                       fr;
    logic [bfha_pkg::REQ_W-1:0] req;
    logic [bfha_pkg::OFF_W-1:0] rel;
  } heap_cmd_t;

  typedef struct {
    logic [bfha_pkg::OFF_W-1:0]    off;
    logic [bfha_pkg::STATUS_W-1:0] st;
  } heap_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [bfha_pkg::CMD_W-1:0]    command = bfha_pkg::CMD_NOP;
  logic                          fresh = 1'b0;
  logic [bfha_pkg::REQ_W-1:0]    request_size = '0;
  logic [bfha_pkg::OFF_W-1:0]    release_offset = '0;
  logic                          busy;
  logic                          done;
  logic [bfha_pkg::OFF_W-1:0]    payload_offset;
  logic [bfha_pkg::STATUS_W-1:0] status;

  heap_cmd_t    cmd_q[$];
  heap_result_t result_q[$];
  int           live_offs[$];
  int           gap_left = 0;
  int           mismatches = 0;
  int           stall_cnt = 0;

  // shadow copy of the header store and list head
  int unsigned hsize [SLOTS];
  int unsigned hnext [SLOTS];
  bit          hused [SLOTS];
  bit          hnv   [SLOTS];
  int unsigned fhead = 0;
  bit          fhead_v = 1'b1;

  best_fit_heap_allocator_core #(
    .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
  ) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command), .fresh(fresh),
    .request_size(request_size), .release_offset(release_offset), .done(done),
    .payload_offset(payload_offset), .status(status)
  );

  always #5 clk = ~clk;

  // best-fit allocation over the shadow free list
  task automatic heap_alloc(input int unsigned req, output int unsigned off,
                            output logic [bfha_pkg::STATUS_W-1:0] st);
    int unsigned need, cur, prev, best, best_prev, best_diff, n, nxt, rem, split_slot;
    bit have_cur, have_prev, found, best_has_prev, nxt_v;
    off = 0;
    prev = 0; best = 0; best_prev = 0; best_diff = 32'hFFFF_FFFF;
    have_prev = 0; found = 0; best_has_prev = 0;
    if (req == 0) begin
      st = bfha_pkg::STAT_ZERO_SIZE;
      return;
    end
    need = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    cur = fhead;
    have_cur = fhead_v;
    for (n = 0; have_cur && n < SLOTS; n++) begin
      if (cur >= SLOTS) break;
      if (hsize[cur] >= need && hsize[cur] - need <= best_diff) begin
        best_diff = hsize[cur] - need;
        best = cur;
        best_prev = prev;
        best_has_prev = have_prev;
        found = 1;
      end
      prev = cur;
      have_prev = 1;
      have_cur = hnv[cur];
      cur = hnext[cur];
    end
    if (!found) begin
      st = bfha_pkg::STAT_NO_FIT;
      return;
    end
    nxt = hnext[best];
    nxt_v = hnv[best];
    rem = hsize[best] - need;
    split_slot = (best * ALIGN_BYTES + HDR_SPAN + need) / ALIGN_BYTES;
    // split the leftover off as a new free block in the same list position
    if (rem > HEADER_BYTES + ALIGN_BYTES && split_slot < SLOTS) begin
      hsize[split_slot] = rem - HDR_SPAN;
      hused[split_slot] = 0;
      hnext[split_slot] = nxt;
      hnv[split_slot] = nxt_v;
      nxt = split_slot;
      nxt_v = 1;
    end
    if (best_has_prev) begin
      hnext[best_prev] = nxt;
      hnv[best_prev] = nxt_v;
    end else begin
      fhead = nxt;
      fhead_v = nxt_v;
    end
    hsize[best] = need;
    hused[best] = 1;
    hnext[best] = 0;
    hnv[best] = 0;
    off = best * ALIGN_BYTES + HDR_SPAN;
    st = bfha_pkg::STAT_OK;
  endtask

  // address-ordered insertion of a released block
  task automatic heap_release(input int unsigned poff,
                              output logic [bfha_pkg::STATUS_W-1:0] st);
    int unsigned hpos, blk, cur, n, nx;
    st = bfha_pkg::STAT_NOT_ALLOC;
    if (poff < HDR_SPAN) return;
    hpos = poff - HDR_SPAN;
    if (hpos % ALIGN_BYTES != 0) return;
    blk = hpos / ALIGN_BYTES;
    if (blk >= SLOTS) return;
    if (!hused[blk]) return;
    if (!fhead_v || fhead >= SLOTS || blk < fhead) begin
      hnext[blk] = fhead;
      hnv[blk] = fhead_v && fhead < SLOTS;
      fhead = blk;
      fhead_v = 1;
    end else begin
      cur = fhead;
      for (n = 0; n < SLOTS; n++) begin
        nx = hnext[cur];
        if (!hnv[cur] || nx >= SLOTS || nx >= blk) break;
        cur = nx;
      end
      hnext[blk] = hnext[cur];
      hnv[blk] = hnv[cur];
      hnext[cur] = blk;
      hnv[cur] = 1;
    end
    hused[blk] = 0;
    st = bfha_pkg::STAT_OK;
  endtask

  // expected result of one command, also tracks live payload offsets
  task automatic heap_predict(input heap_cmd_t c, output heap_result_t r);
    int unsigned off;
    r.off = '0;
    r.st = bfha_pkg::STAT_OK;
    case (c.cmd)
      bfha_pkg::CMD_INIT: begin
        if (c.fr) begin
          hsize[0] = HEAP_BYTES - HDR_SPAN;
          hused[0] = 0;
          hnext[0] = 0;
          hnv[0] = 0;
        end
        fhead = 0;
        fhead_v = 1;
      end
      bfha_pkg::CMD_ALLOC: begin
        heap_alloc(c.req, off, r.st);
        r.off = off[bfha_pkg::OFF_W-1:0];
        if (r.st == bfha_pkg::STAT_OK) live_offs.push_back(off);
      end
      bfha_pkg::CMD_FREE: begin
        heap_release(c.rel, r.st);
        if (r.st == bfha_pkg::STAT_OK)
          foreach (live_offs[i])
            if (live_offs[i] == c.rel) begin
              live_offs.delete(i);
              break;
            end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic heap_cmd_t make_cmd(logic [bfha_pkg::CMD_W-1:0] cmd, logic fr,
                                         int req, int rel);
    heap_cmd_t c;
    c.cmd = cmd;
    c.fr = fr;
    c.req = req[bfha_pkg::REQ_W-1:0];
    c.rel = rel[bfha_pkg::OFF_W-1:0];
    return c;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // driver: one transfer per start/!busy edge, random gaps between items
  always @(posedge clk) begin
    heap_cmd_t    c;
    heap_result_t r;
    bit           take;
    int           g;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      take = start && !busy;
      if (take) begin
        c = make_cmd(command, fresh, request_size, release_offset);
        heap_predict(c, r);
        result_q.push_back(r);
      end
      if (take || !start) begin
        g = take ? pick_gap() : gap_left;
        if (g == 0 && cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          command <= c.cmd;
          fresh <= c.fr;
          request_size <= c.req;
          release_offset <= c.rel;
          start <= 1'b1;
          gap_left <= 0;
        end else begin
          start <= 1'b0;
          gap_left <= (g > 0) ? g - 1 : 0;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    heap_result_t e;
    if (!rst && done) begin
      if (result_q.size() == 0) begin
        report("unexpected result, status", status, 0);
      end else begin
        e = result_q.pop_front();
        if (status !== e.st) report("status", status, e.st);
        if (payload_offset !== e.off) report("payload_offset", payload_offset, e.off);
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cmd_q.size() != 0 || start || result_q.size() != 0) @(posedge clk);
  endtask

  // random commands, mostly small allocations and frees of live blocks
  task automatic push_random(input int n);
    int r, sz;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        sz = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 200) : $urandom_range(0, 4095);
        cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'($urandom_range(0, 1)), sz,
                                 $urandom_range(0, 4095)));
      end else if (r < 85 && live_offs.size() > 0) begin
        cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 4095),
                                 live_offs[$urandom_range(0, live_offs.size() - 1)]));
      end else if (r < 90) begin
        cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 4095), $urandom_range(0, 4095)));
      end else if (r < 94) begin
        cmd_q.push_back(make_cmd(bfha_pkg::CMD_NOP, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 4095), $urandom_range(0, 4095)));
      end else if (r < 97) begin
        cmd_q.push_back(make_cmd(bfha_pkg::CMD_INIT, 1'b1, $urandom_range(0, 4095),
                                 $urandom_range(0, 4095)));
      end else begin
        cmd_q.push_back(make_cmd(bfha_pkg::CMD_INIT, 1'b0, $urandom_range(0, 4095),
                                 $urandom_range(0, 4095)));
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      hsize[i] = 0; hnext[i] = 0; hused[i] = 0; hnv[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // fresh heap, zero size, too large, exact whole-heap fit, empty list
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_INIT, 1'b1, 0, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 0, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 4095, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, HEAP_BYTES - HDR_SPAN, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 1, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, HDR_SPAN));
    // double free and malformed offsets
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, HDR_SPAN));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, HDR_SPAN - 1));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, HDR_SPAN + 4));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, 4095));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_NOP, 1'b1, 4095, 4095));
    // split allocations
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b1, 1, 4095));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 100, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 24, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 8, 0));
    wait_drained();

    // free out of order so a block lands before the head, then stale headers
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, live_offs[2]));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, live_offs[0]));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 20, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_INIT, 1'b0, 0, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_ALLOC, 1'b0, 8, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_INIT, 1'b1, 0, 0));
    cmd_q.push_back(make_cmd(bfha_pkg::CMD_FREE, 1'b0, 0, live_offs[1]));
    wait_drained();

    // random batches, each refilled once the previous one has drained
    for (int b = 0; b < BATCHES; b++) begin
      push_random(BATCH_LEN);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bfha_pkg.sv
rtl/bfha_ram.sv
rtl/best_fit_heap_allocator_core.sv
rtl/bfha_checker.sv
tb/best_fit_heap_allocator_core_tb.sv
